/* rtl/core/sfd_pkg.sv */
// Shared types and constants for the start/type/length frame deframer.
// No dependencies; imported by every module under rtl/core.
package sfd_pkg;

    localparam int unsigned HDR_BYTES    = 5;
    localparam int unsigned HDR_CNT_W    = 3;
    localparam int unsigned LEN_W        = 32;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 1'b1;

    localparam logic [7:0]       START_BYTE_RST = 8'hA5;
    localparam logic [LEN_W-1:0] MAX_LEN_RST    = 32'h0010_0000;

    localparam logic [HDR_CNT_W-1:0] HDR_LAST = 3'd4;

    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_sfd_phase;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_sfd_in;

    typedef struct packed {
        logic [7:0]       frame_type;
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       payload_byte;
        logic             empty_frame;
        logic             last;
    } t_sfd_out;

    typedef logic [HDR_BYTES-1:0][7:0] t_sfd_hdr;

endpackage

/* rtl/core/sfd_in_reg.sv */
// Input register stage of the deframer.
// Depends on sfd_pkg for the input item type.
module sfd_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sfd_pkg::t_sfd_in i_in_data,
    input  logic            i_take,
    output logic            o_vld,
    output sfd_pkg::t_sfd_in o_data
);
    import sfd_pkg::*;

    logic     r_vld;
    t_sfd_in  r_data;
    logic     n_vld;
    logic     w_load;

    // Stage refills in the same cycle it drains.
    assign o_in_stall = r_vld && !i_take;
    assign w_load     = i_in_valid && !o_in_stall;

    always_comb begin
        n_vld = r_vld;
        if (w_load) begin
            n_vld = 1'b1;
        end else if (i_take) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_in_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

/* rtl/core/sfd_core.sv */
// Frame state machine: hunt, header collection with resync, payload tagging.
// Depends on sfd_pkg for types and constants.
module sfd_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  sfd_pkg::t_sfd_in         i_item,
    input  logic [7:0]               i_start_byte,
    input  logic [sfd_pkg::LEN_W-1:0] i_max_len,
    output logic                     o_res_vld,
    output sfd_pkg::t_sfd_out        o_res
);
    import sfd_pkg::*;

    t_sfd_phase             r_phase,  n_phase;
    logic [HDR_CNT_W-1:0]   r_count,  n_count;
    logic [LEN_W-1:0]       r_remain, n_remain;
    t_sfd_hdr               r_hdr,    n_hdr;

    t_sfd_hdr               w_hdr_new;
    logic [LEN_W-1:0]       w_len_held;
    logic [LEN_W-1:0]       w_len_new;
    logic                   w_found;
    logic [HDR_CNT_W-1:0]   w_idx;

    assign w_len_held = {r_hdr[4], r_hdr[3], r_hdr[2], r_hdr[1]};

    always_comb begin
        w_hdr_new = r_hdr;
        if (r_count <= HDR_LAST) begin
            w_hdr_new[r_count] = i_item.data_byte;
        end
    end

    assign w_len_new = {w_hdr_new[4], w_hdr_new[3], w_hdr_new[2], w_hdr_new[1]};

    // First held header byte that matches the start byte.
    always_comb begin
        w_found = 1'b0;
        w_idx   = '0;
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (!w_found && w_hdr_new[i] == i_start_byte) begin
                w_found = 1'b1;
                w_idx   = HDR_CNT_W'(i);
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_remain  = r_remain;
        n_hdr     = r_hdr;
        o_res_vld = 1'b0;
        o_res     = '{frame_type: r_hdr[0], frame_length: w_len_held,
                      payload_byte: i_item.data_byte, empty_frame: 1'b0,
                      last: 1'b0};

        if (i_item.action == ACT_CLEAR) begin
            n_phase  = PH_HUNT;
            n_count  = '0;
            n_remain = '0;
        end else begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    o_res_vld = 1'b1;
                    o_res.last = (r_remain <= LEN_W'(1));
                    if (r_remain <= LEN_W'(1)) begin
                        n_remain = '0;
                        n_phase  = PH_HUNT;
                        n_count  = '0;
                    end else begin
                        n_remain = r_remain - LEN_W'(1);
                    end
                end
                PH_HEADER: begin
                    n_hdr = w_hdr_new;
                    if (r_count < HDR_LAST) begin
                        n_count = r_count + HDR_CNT_W'(1);
                    end else if (w_len_new > i_max_len) begin
                        // lost sync: drop start byte, rescan held header bytes
                        if (w_found) begin
                            n_phase = PH_HEADER;
                            n_count = HDR_LAST - w_idx;
                            unique case (w_idx)
                                3'd0:    n_hdr[3:0] = w_hdr_new[4:1];
                                3'd1:    n_hdr[2:0] = w_hdr_new[4:2];
                                3'd2:    n_hdr[1:0] = w_hdr_new[4:3];
                                3'd3:    n_hdr[0]   = w_hdr_new[4];
                                default: n_hdr      = w_hdr_new;
                            endcase
                        end else begin
                            n_phase = PH_HUNT;
                            n_count = '0;
                        end
                    end else begin
                        n_count = '0;
                        if (w_len_new == '0) begin
                            n_phase   = PH_HUNT;
                            o_res_vld = 1'b1;
                            o_res     = '{frame_type: w_hdr_new[0], frame_length: '0,
                                          payload_byte: 8'h00, empty_frame: 1'b1,
                                          last: 1'b1};
                        end else begin
                            n_remain = w_len_new;
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                    n_count = '0;
                    if (i_item.data_byte == i_start_byte) begin
                        n_phase = PH_HEADER;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_count  <= '0;
            r_remain <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_remain <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_hdr <= n_hdr;
        end
    end

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_remain != '0)
        else $error("payload phase with nothing remaining");

    a_header_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_count <= HDR_LAST)
        else $error("header count out of range");

    a_hunt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HEADER |-> r_count == '0)
        else $error("header count left over outside header phase");

    a_result_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && !o_res.empty_frame) |-> r_phase == PH_PAYLOAD)
        else $error("payload result outside payload phase");

endmodule

/* rtl/core/sfd_out_reg.sv */
// Result register stage of the deframer.
// Depends on sfd_pkg for the result item type.
module sfd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sfd_pkg::t_sfd_out i_res,
    output logic             o_free,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sfd_pkg::t_sfd_out o_out_data
);
    import sfd_pkg::*;

    logic     r_vld;
    logic     n_vld;
    t_sfd_out r_res;

    // Free when empty or when the held result transfers this cycle.
    assign o_free = !r_vld || !i_out_stall;

    always_comb begin
        n_vld = r_vld;
        if (i_load) begin
            n_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_vld;
    assign o_out_data  = r_res;

endmodule

/* rtl/core/sof_length_frame_deframer.sv */
// Start/type/length frame deframer, one stream byte per transfer.
// An accepted byte is held in the input reg; its result is then registered in
// the result reg before it is offered at the output.
// Throughput: one byte per cycle; the only limit is the result register draining.
// Reset (i_rst_n low, synchronous): hunt phase, counters cleared, both stages
// empty, start byte 0xA5 and maximum length 2^20. Header bytes need no reset.
module sof_length_frame_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sfd_pkg::t_sfd_in               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sfd_pkg::t_sfd_out              o_out_data,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import sfd_pkg::*;

    logic [7:0]       r_start;
    logic [LEN_W-1:0] r_max_len;

    logic             w_in_vld;
    t_sfd_in          w_item;
    logic             w_free;
    logic             w_fire;
    logic             w_res_vld;
    t_sfd_out         w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= START_BYTE_RST;
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_BYTE: r_start   <= i_cfg_wdata[7:0];
                CFG_MAX_LEN:    r_max_len <= i_cfg_wdata[LEN_W-1:0];
                default:        r_start   <= r_start;
            endcase
        end
    end

    assign w_fire = w_in_vld && w_free;

    sfd_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_take     (w_fire),
        .o_vld      (w_in_vld),
        .o_data     (w_item)
    );

    sfd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_item       (w_item),
        .i_start_byte (r_start),
        .i_max_len    (r_max_len),
        .o_res_vld    (w_res_vld),
        .o_res        (w_res)
    );

    sfd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_fire && w_res_vld),
        .i_res       (w_res),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* test/testbench.sv */
// Self-checking testbench for sof_length_frame_deframer: a directed table, then
// random framed byte streams under several register settings and random stalls.
// Depends on sfd_pkg and the deframer RTL only.
`timescale 1ns / 100ps

module testbench;
    import sfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int unsigned PHASE_BYTES = 350;
    localparam int unsigned SMALL_LEN   = 12;

    typedef struct packed {
        logic     typed;
        t_sfd_out want;
        t_sfd_in  item;
    } t_dir_row;

    localparam t_sfd_out NONE  = '0;
    localparam int       DIR_N = 29;
    // typed rows: the result is obvious from the header bytes
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b0, NONE, '{ACT_DATA, 8'hA5}},
        '{1'b0, NONE, '{ACT_DATA, 8'h3C}},
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b1, '{8'h3C, 32'd0, 8'h00, 1'b1, 1'b1}, '{ACT_DATA, 8'h00}},
        '{1'b0, NONE, '{ACT_DATA, 8'hA5}},
        '{1'b0, NONE, '{ACT_DATA, 8'hFF}},
        '{1'b0, NONE, '{ACT_DATA, 8'h02}},
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b1, '{8'hFF, 32'd2, 8'hA5, 1'b0, 1'b0}, '{ACT_DATA, 8'hA5}},
        '{1'b1, '{8'hFF, 32'd2, 8'hFF, 1'b0, 1'b1}, '{ACT_DATA, 8'hFF}},
        '{1'b0, NONE, '{ACT_DATA, 8'hA5}},
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b0, NONE, '{ACT_DATA, 8'hA5}},
        // length too big: rescan finds the start byte in the third length byte
        '{1'b0, NONE, '{ACT_DATA, 8'h07}},
        '{1'b0, NONE, '{ACT_DATA, 8'h01}},
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b0, NONE, '{ACT_DATA, 8'h00}},
        '{1'b1, '{8'h07, 32'd1, 8'h5A, 1'b0, 1'b1}, '{ACT_DATA, 8'h5A}},
        '{1'b0, NONE, '{ACT_DATA, 8'hA5}},
        '{1'b0, NONE, '{ACT_CLEAR, 8'h42}},
        '{1'b0, NONE, '{ACT_DATA, 8'h42}}
    };

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_sfd_in               i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_sfd_out              o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_START_BYTE;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // predictor state and register copies
    t_sfd_phase  st_phase = PH_HUNT;
    logic [7:0]  hdr [HDR_BYTES];
    int          hdr_cnt  = 0;
    logic [31:0] pay_left = '0;
    logic [7:0]  cfg_start = START_BYTE_RST;
    logic [31:0] cfg_max   = MAX_LEN_RST;

    t_sfd_out    results_due [$];
    int unsigned in_gap_max  = 0;
    int unsigned out_gap_max = 0;
    int unsigned out_hold    = 0;
    int unsigned bytes_sent  = 0;
    int unsigned mismatches  = 0;
    int unsigned cycles      = 0;

    sof_length_frame_deframer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** sof_length_frame_deframer: FAILED **");
            $finish;
        end
    end

    // Works out the result, if any, of one accepted byte or clear.
    task automatic deframe_byte(input t_sfd_in item, output bit has_res,
                                output t_sfd_out res);
        logic [31:0] hlen;
        int          k;
        int          at;
        has_res = 1'b0;
        res     = '0;
        at      = -1;
        if (item.action == ACT_CLEAR) begin
            st_phase = PH_HUNT;
            hdr_cnt  = 0;
            pay_left = '0;
        end else if (st_phase == PH_PAYLOAD) begin
            has_res          = 1'b1;
            res.frame_type   = hdr[0];
            res.frame_length = {hdr[4], hdr[3], hdr[2], hdr[1]};
            res.payload_byte = item.data_byte;
            res.last         = (pay_left <= 1);
            if (pay_left <= 1) begin
                pay_left = '0;
                st_phase = PH_HUNT;
                hdr_cnt  = 0;
            end else begin
                pay_left = pay_left - 1;
            end
        end else if (st_phase == PH_HEADER) begin
            hdr[hdr_cnt] = item.data_byte;
            hdr_cnt++;
            if (hdr_cnt == HDR_BYTES) begin
                hlen = {hdr[4], hdr[3], hdr[2], hdr[1]};
                if (hlen > cfg_max) begin
                    // lost sync: restart from the first held start byte, if any
                    for (k = 0; k < HDR_BYTES; k++)
                        if (at < 0 && hdr[k] == cfg_start) at = k;
                    if (at >= 0) begin
                        for (k = at + 1; k < HDR_BYTES; k++) hdr[k-at-1] = hdr[k];
                        hdr_cnt = HDR_BYTES - 1 - at;
                    end else begin
                        hdr_cnt  = 0;
                        st_phase = PH_HUNT;
                    end
                end else begin
                    hdr_cnt = 0;
                    if (hlen == 0) begin
                        st_phase        = PH_HUNT;
                        has_res         = 1'b1;
                        res.frame_type  = hdr[0];
                        res.empty_frame = 1'b1;
                        res.last        = 1'b1;
                    end else begin
                        pay_left = hlen;
                        st_phase = PH_PAYLOAD;
                    end
                end
            end
        end else if (item.data_byte == cfg_start) begin
            st_phase = PH_HEADER;
            hdr_cnt  = 0;
        end
    endtask

    // Returns at the edge where the transfer is taken.
    task automatic push_byte(input t_sfd_in item, input bit typed = 1'b0,
                             input t_sfd_out want = '0);
        int unsigned gap;
        bit          has_res;
        t_sfd_out    res;
        gap = $urandom_range(in_gap_max, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        deframe_byte(item, has_res, res);
        if (has_res) results_due.push_back(typed ? want : res);
        if (item.action == ACT_DATA) bytes_sent++;
    endtask

    // Block idle: nothing owed, and headroom for bytes that give no result.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] start, input logic [31:0] max_len);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_START_BYTE;
        i_cfg_wdata <= {24'h0, start};
        @(posedge i_clk);
        cfg_start    = start;
        i_cfg_index <= CFG_MAX_LEN;
        i_cfg_wdata <= max_len;
        @(posedge i_clk);
        cfg_max   = max_len;
        i_cfg_we <= 1'b0;
    endtask

    function automatic int unsigned pick_gap();
        case ($urandom_range(2, 0))
            0:       return 0;
            1:       return 6;
            default: return 2;
        endcase
    endfunction

    // One random chunk of stream: mostly well-formed frames, some noise and clears.
    task automatic send_frame();
        t_sfd_in         b;
        int unsigned     kind;
        int unsigned     n;
        int              k;
        logic [31:0]     flen;
        logic [31:0]     alt;
        logic [7:0]      ftype;
        longint unsigned span;
        bit              good;
        kind     = $urandom_range(99, 0);
        b.action = ACT_DATA;
        if (kind < 4 || (st_phase == PH_PAYLOAD && pay_left > 16)) begin
            b.action    = ACT_CLEAR;
            b.data_byte = 8'($urandom);
            push_byte(b);
            return;
        end
        if (kind < 12) begin
            n = $urandom_range(4, 1);
            repeat (n) begin
                b.data_byte = 8'($urandom);
                push_byte(b);
            end
            return;
        end
        ftype = ($urandom_range(5, 0) == 0) ? cfg_start : 8'($urandom);
        good  = ($urandom_range(9, 0) < 7) || (cfg_max == 32'hFFFF_FFFF);
        if (good) begin
            flen = $urandom_range((cfg_max < SMALL_LEN) ? cfg_max : SMALL_LEN, 0);
        end else if ($urandom_range(2, 0) == 0) begin
            flen = cfg_max + 1;
        end else begin
            span = 64'hFFFF_FFFF - cfg_max;
            flen = 32'(64'(cfg_max) + 1 + (64'($urandom) % span));
            if ($urandom_range(2, 0) == 0) begin
                alt = flen;
                k   = $urandom_range(3, 0);
                alt[8*k +: 8] = cfg_start;
                if (alt > cfg_max) flen = alt;
            end
        end
        b.data_byte = cfg_start;
        push_byte(b);
        b.data_byte = ftype;
        push_byte(b);
        for (k = 0; k < 4; k++) begin
            b.data_byte = flen[8*k +: 8];
            push_byte(b);
        end
        if (good) begin
            for (k = 0; k < int'(flen); k++) begin
                b.data_byte = ($urandom_range(7, 0) == 0) ? cfg_start : 8'($urandom);
                push_byte(b);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold    = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result with none expected: %p", o_out_data);
                    mismatches++;
                end else begin
                    t_sfd_out want;
                    want = results_due.pop_front();
                    if (o_out_data.frame_type !== want.frame_type) begin
                        $error("frame_type: expected %0h, got %0h",
                               want.frame_type, o_out_data.frame_type);
                        mismatches++;
                    end
                    if (o_out_data.frame_length !== want.frame_length) begin
                        $error("frame_length: expected %0h, got %0h",
                               want.frame_length, o_out_data.frame_length);
                        mismatches++;
                    end
                    if (o_out_data.payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.payload_byte, o_out_data.payload_byte);
                        mismatches++;
                    end
                    if (o_out_data.empty_frame !== want.empty_frame) begin
                        $error("empty_frame: expected %0h, got %0h",
                               want.empty_frame, o_out_data.empty_frame);
                        mismatches++;
                    end
                    if (o_out_data.last !== want.last) begin
                        $error("last: expected %0h, got %0h", want.last, o_out_data.last);
                        mismatches++;
                    end
                end
                out_hold = $urandom_range(out_gap_max, 0);
            end
            if (out_hold > 0) begin
                i_out_stall <= 1'b1;
                out_hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        logic [7:0]  set_start [5];
        logic [31:0] set_max [5];
        int          p;
        int          r;
        set_start = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), START_BYTE_RST};
        set_max   = '{32'd0, 32'hFFFF_FFFF, $urandom_range(SMALL_LEN, 1), $urandom, 32'd5};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows run with the reset register values
        in_gap_max  = 3;
        out_gap_max = 3;
        for (r = 0; r < DIR_N; r++)
            push_byte(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want);
        drain();

        for (p = 0; p < 5; p++) begin
            configure(set_start[p], set_max[p]);
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) begin
                if ($urandom_range(15, 0) == 0) begin
                    in_gap_max  = pick_gap();
                    out_gap_max = pick_gap();
                end
                send_frame();
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("** sof_length_frame_deframer: PASSED **");
        end else begin
            $display("** sof_length_frame_deframer: FAILED **");
        end
        $finish;
    end

endmodule
